/* hdl/i2cm_pkg.sv */
package i2cm_pkg;

	// Operation codes of the request channel.
	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_START = 3'd1;
	localparam logic [2:0] OP_SEND  = 3'd2;
	localparam logic [2:0] OP_RECV  = 3'd3;
	localparam logic [2:0] OP_STOP  = 3'd4;

	// Register map: register index is paddr[2].
	localparam int unsigned PADDR_W = 3;
	localparam logic REG_DELAY_TICKS = 1'b0;
	localparam logic REG_ACK_TIMEOUT = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [9:0] DELAY_TICKS_RESET = 10'd30;
	localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd255;

	// Default depth of the queue between front and back.
	localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

	// Request as it arrives on the port.
	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] data_byte;
		logic [6:0] target_address;
		logic       read_not_write;
		logic       send_ack_level;
		logic       sda_level;
	} cmd_t;

	// Result as it leaves the block.
	typedef struct packed {
		logic       scl_drive;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic       ack_seen;
		logic [7:0] read_byte;
		logic       rejected;
	} res_t;

	// Request class decided by the front end.
	typedef enum logic [2:0] {
		K_TICK,
		K_START,
		K_SEND,
		K_RECV,
		K_STOP
	} kind_t;

	// Classified request carried through the queue.
	typedef struct packed {
		kind_t      kind;
		logic [7:0] tx_byte;
		logic       ack_level;
		logic       sda_level;
	} item_t;

	// Configuration handed to the sequencer.
	typedef struct packed {
		logic [9:0] delay_ticks;
		logic [7:0] ack_timeout;
	} cfg_t;

	// Line sequencer phases.
	typedef enum logic [4:0] {
		PH_IDLE = 5'd0,
		PH_ST0  = 5'd1,
		PH_ST1  = 5'd2,
		PH_ST2  = 5'd3,
		PH_ST3  = 5'd4,
		PH_ST4  = 5'd5,
		PH_ST5  = 5'd6,
		PH_ST6  = 5'd7,
		PH_ST7  = 5'd8,
		PH_TXH  = 5'd9,
		PH_TXL  = 5'd10,
		PH_POLL = 5'd11,
		PH_RXH  = 5'd12,
		PH_RXL  = 5'd13,
		PH_RXA  = 5'd14,
		PH_SP0  = 5'd15,
		PH_SP1  = 5'd16,
		PH_SP2  = 5'd17
	} phase_t;

endpackage

/* hdl/i2c_master_byte_engine.sv */
// I2C master byte engine. Requests on the cmd channel are either commands (start with
// address, send byte, receive byte, stop) or ticks that advance the SCL/SDA sequencer and
// carry the sampled SDA level; every request yields exactly one result on the res channel
// with the line levels, busy, done, acknowledge and read byte after that request. A
// request is accepted in every cycle while the internal queue has room, so the sustained
// rate is one request per clock; a request passes through the classification stage,
// the queue and the sequencer result register. The sequencer executes one request per
// cycle out of the queue while the result register can take it, so a stall on the
// result side only holds the request side once the queue of QUEUE_DEPTH entries is
// full. Each line change lasts delay_ticks ticks (0 behaves as 1); the acknowledge poll
// lasts up to ack_timeout+1 ticks. Registers: delay_ticks at byte address 0, ack_timeout
// at byte address 4; write them only while no command is in progress.
module i2c_master_byte_engine #(
	parameter int unsigned QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  i2cm_pkg::cmd_t                cmd,
	output logic                          res_valid,
	input  logic                          res_stall,
	output i2cm_pkg::res_t                res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [i2cm_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import i2cm_pkg::*;

	cfg_t  cfg_q;
	logic  q_full;
	logic  q_push;
	item_t q_push_item;
	logic  q_pop;
	logic  q_valid;
	item_t q_pop_item;
	logic  reg_index;

	// Configuration registers.
	assign pready    = 1'b1;
	assign reg_index = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_ticks <= DELAY_TICKS_RESET;
			cfg_q.ack_timeout <= ACK_TIMEOUT_RESET;
		end else if (psel && penable && pwrite) begin
			case (reg_index)
				REG_DELAY_TICKS: cfg_q.delay_ticks <= pwdata[9:0];
				REG_ACK_TIMEOUT: cfg_q.ack_timeout <= pwdata[7:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_index)
			REG_DELAY_TICKS: prdata = {22'd0, cfg_q.delay_ticks};
			REG_ACK_TIMEOUT: prdata = {24'd0, cfg_q.ack_timeout};
			default: prdata = '0;
		endcase
	end

	// Front end: accept and classify requests.
	i2cm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (q_push_item)
	);

	// Queue between front end and sequencer.
	i2cm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_item  (q_pop_item)
	);

	// Back end: line sequencer and result register.
	i2cm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_pop_item),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

/* hdl/i2cm_front.sv */
module i2cm_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  i2cm_pkg::cmd_t cmd,
	input  logic          q_full,
	output logic          q_push,
	output i2cm_pkg::item_t q_item
);
	import i2cm_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	item_t item_dec;

	// Classify the request and prepare the byte that will be shifted out.
	always_comb begin
		item_dec.ack_level = cmd.send_ack_level;
		item_dec.sda_level = cmd.sda_level;
		item_dec.tx_byte   = cmd.data_byte;
		case (cmd.operation)
			OP_START: begin
				item_dec.kind    = K_START;
				item_dec.tx_byte = {cmd.target_address, cmd.read_not_write};
			end
			OP_SEND: item_dec.kind = K_SEND;
			OP_RECV: item_dec.kind = K_RECV;
			OP_STOP: item_dec.kind = K_STOP;
			default: item_dec.kind = K_TICK;
		endcase
	end

	// The stage holds while the queue is full.
	assign cmd_stall = valid_s1 && q_full;
	assign q_push    = valid_s1 && !q_full;
	assign q_item    = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd_stall && cmd_valid) begin
			item_s1 <= item_dec;
		end
	end

endmodule

/* hdl/i2cm_queue.sv */
module i2cm_queue #(
	parameter int unsigned DEPTH = i2cm_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  i2cm_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            pop_valid,
	output i2cm_pkg::item_t pop_item
);
	import i2cm_pkg::*;

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	item_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_item  = mem_q[rd_ptr_q];

	// Pointers wrap at the depth, which need not be a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* hdl/i2cm_back.sv */
module i2cm_back (
	input  logic            clk,
	input  logic            arst_n,
	input  i2cm_pkg::cfg_t  cfg,
	input  logic            q_valid,
	input  i2cm_pkg::item_t q_item,
	output logic            q_pop,
	output logic            res_valid,
	input  logic            res_stall,
	output i2cm_pkg::res_t  res
);
	import i2cm_pkg::*;

	// Sequencer state.
	phase_t     phase_q;
	logic [3:0] bit_index_q;
	logic [7:0] shift_q;
	logic [9:0] delay_q;
	logic [7:0] timeout_q;
	logic       scl_q;
	logic       sda_q;
	logic       ack_q;
	logic       ack_to_send_q;
	logic [7:0] read_q;

	// Result register.
	logic res_valid_q;
	res_t res_q;

	// Next values.
	phase_t     phase_d;
	logic [3:0] bit_index_d;
	logic [7:0] shift_d;
	logic [9:0] delay_d;
	logic [7:0] timeout_d;
	logic       scl_d;
	logic       sda_d;
	logic       ack_d;
	logic       ack_to_send_d;
	logic [7:0] read_d;
	logic       done_d;

	// Step decisions.
	logic       enter;
	logic       rej;
	logic       expire;
	logic       count_down;
	logic       poll_end;
	logic       poll_wait;
	logic [3:0] bit_inc;

	assign bit_inc = bit_index_q + 4'd1;

	// One request is executed per cycle whenever the result register can take it.
	assign q_pop     = q_valid && (!res_valid_q || !res_stall);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Next phase and the kind of step taken.
	always_comb begin
		phase_d    = phase_q;
		enter      = 1'b0;
		rej        = 1'b0;
		expire     = 1'b0;
		count_down = 1'b0;
		poll_end   = 1'b0;
		poll_wait  = 1'b0;
		if (q_pop) begin
			if (q_item.kind != K_TICK) begin
				if (phase_q != PH_IDLE) begin
					rej = 1'b1;
				end else begin
					enter = 1'b1;
					case (q_item.kind)
						K_START: phase_d = PH_ST0;
						K_SEND:  phase_d = PH_TXH;
						K_RECV:  phase_d = PH_RXH;
						K_STOP:  phase_d = PH_SP0;
						default: phase_d = PH_IDLE;
					endcase
				end
			end else if (phase_q == PH_IDLE) begin
				phase_d = PH_IDLE;
			end else if (phase_q == PH_POLL) begin
				if (!q_item.sda_level || timeout_q == '0) begin
					poll_end = 1'b1;
					phase_d  = PH_IDLE;
				end else begin
					poll_wait = 1'b1;
				end
			end else if (delay_q > 10'd1) begin
				count_down = 1'b1;
			end else begin
				expire = 1'b1;
				enter  = 1'b1;
				case (phase_q)
					PH_ST0: phase_d = PH_ST1;
					PH_ST1: phase_d = PH_ST2;
					PH_ST2: phase_d = PH_ST3;
					PH_ST3: phase_d = PH_ST4;
					PH_ST4: phase_d = PH_ST5;
					PH_ST5: phase_d = PH_ST6;
					PH_ST6: phase_d = PH_ST7;
					PH_ST7: phase_d = PH_TXH;
					PH_TXH: phase_d = PH_TXL;
					PH_TXL: phase_d = bit_inc[3] ? PH_POLL : PH_TXH;
					PH_RXH: phase_d = PH_RXL;
					PH_RXL: phase_d = bit_inc[3] ? PH_RXA : PH_RXH;
					PH_SP0: phase_d = PH_SP1;
					PH_SP1: phase_d = PH_SP2;
					default: begin
						phase_d = PH_IDLE;
						enter   = 1'b0;
					end
				endcase
			end
		end
	end

	// Line levels, counters and shift register for the chosen step.
	always_comb begin
		bit_index_d   = bit_index_q;
		shift_d       = shift_q;
		delay_d       = delay_q;
		timeout_d     = timeout_q;
		scl_d         = scl_q;
		sda_d         = sda_q;
		ack_d         = ack_q;
		ack_to_send_d = ack_to_send_q;
		read_d        = read_q;
		done_d        = 1'b0;

		// Load the new command.
		if (enter && !expire) begin
			case (q_item.kind)
				K_START: shift_d = q_item.tx_byte;
				K_SEND: begin
					shift_d     = q_item.tx_byte;
					bit_index_d = '0;
				end
				K_RECV: begin
					sda_d         = 1'b1;
					shift_d       = '0;
					bit_index_d   = '0;
					ack_to_send_d = q_item.ack_level;
				end
				default: shift_d = shift_q;
			endcase
		end

		// Acknowledge polling.
		if (poll_end) begin
			ack_d  = q_item.sda_level;
			scl_d  = 1'b0;
			done_d = 1'b1;
		end
		if (poll_wait) begin
			timeout_d = timeout_q - 8'd1;
		end
		if (count_down) begin
			delay_d = delay_q - 10'd1;
		end

		// Work done at the end of a timed step.
		if (expire) begin
			delay_d = '0;
			case (phase_q)
				PH_ST7: bit_index_d = '0;
				PH_TXL: bit_index_d = bit_inc;
				PH_RXH: shift_d = {shift_q[6:0], q_item.sda_level};
				PH_RXL: bit_index_d = bit_inc;
				PH_RXA: begin
					scl_d  = 1'b0;
					read_d = shift_q;
					done_d = 1'b1;
				end
				PH_SP2: begin
					sda_d  = 1'b1;
					done_d = 1'b1;
				end
				default: done_d = 1'b0;
			endcase
		end

		// Line change on entering a phase.
		if (enter) begin
			delay_d = cfg.delay_ticks;
			case (phase_d)
				PH_ST0: sda_d = 1'b1;
				PH_ST1: scl_d = 1'b1;
				PH_ST2: sda_d = 1'b0;
				PH_ST5: scl_d = 1'b0;
				PH_TXH: begin
					sda_d = shift_d[7];
					scl_d = 1'b1;
				end
				PH_TXL: begin
					shift_d = {shift_d[6:0], 1'b0};
					scl_d   = 1'b0;
				end
				PH_POLL: begin
					sda_d     = 1'b1;
					scl_d     = 1'b1;
					timeout_d = cfg.ack_timeout;
				end
				PH_RXH: scl_d = 1'b1;
				PH_RXL: scl_d = 1'b0;
				PH_RXA: begin
					sda_d = ack_to_send_d;
					scl_d = 1'b1;
				end
				PH_SP0: sda_d = 1'b0;
				PH_SP1: scl_d = 1'b1;
				default: scl_d = scl_d;
			endcase
		end
	end

	// Sequencer state updates once per executed request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			bit_index_q   <= '0;
			shift_q       <= '0;
			delay_q       <= '0;
			timeout_q     <= '0;
			scl_q         <= 1'b1;
			sda_q         <= 1'b1;
			ack_q         <= 1'b1;
			ack_to_send_q <= 1'b1;
			read_q        <= '0;
		end else if (q_pop) begin
			phase_q       <= phase_d;
			bit_index_q   <= bit_index_d;
			shift_q       <= shift_d;
			delay_q       <= delay_d;
			timeout_q     <= timeout_d;
			scl_q         <= scl_d;
			sda_q         <= sda_d;
			ack_q         <= ack_d;
			ack_to_send_q <= ack_to_send_d;
			read_q        <= read_d;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (q_pop) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q.scl_drive <= scl_d;
			res_q.sda_drive <= sda_d;
			res_q.busy_res  <= (phase_d != PH_IDLE);
			res_q.done_res  <= done_d;
			res_q.ack_seen  <= ack_d;
			res_q.read_byte <= read_d;
			res_q.rejected  <= rej;
		end
	end

endmodule

/* sim/tb_i2c_master_byte_engine.sv */
`timescale 1ns / 1ps

module tb_i2c_master_byte_engine;
	import i2cm_pkg::*;

	// Operation codes outside the command set; the block treats them as ticks.
	localparam logic [2:0] OP_RSVD5 = 3'd5;
	localparam logic [2:0] OP_RSVD6 = 3'd6;
	localparam logic [2:0] OP_RSVD7 = 3'd7;

	localparam int unsigned IDLE_LIMIT = 2000;
	localparam int unsigned SHOWN_MISMATCHES = 10;
	localparam int unsigned SETTLE_CYCLES = 8;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cmd_valid = 1'b0;
	logic               cmd_stall;
	cmd_t               cmd = '0;
	logic               res_valid;
	logic               res_stall = 1'b0;
	res_t               res;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	i2c_master_byte_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Shadow copy of the register settings and of the line sequencer.
	logic [9:0] delay_ticks_cfg = DELAY_TICKS_RESET;
	logic [7:0] ack_timeout_cfg = ACK_TIMEOUT_RESET;
	phase_t     seq_phase = PH_IDLE;
	logic [3:0] bit_pos = '0;
	logic [7:0] shifter = '0;
	logic [9:0] delay_left = '0;
	logic [7:0] poll_left = '0;
	logic       scl_line = 1'b1;
	logic       sda_line = 1'b1;
	logic       ack_level = 1'b1;
	logic       ack_to_drive = 1'b1;
	logic [7:0] last_read = '0;

	// Line states still to come back on the result channel, oldest first.
	res_t expected_lines[$];

	int unsigned req_count = 0;
	int unsigned res_count = 0;
	int unsigned mismatch_count = 0;
	int unsigned done_count = 0;
	int unsigned reject_count = 0;
	int unsigned idle_cycles = 0;
	int unsigned stall_left = 0;
	bit          calm = 1'b0;

	// One row of the directed sequence: a register write or a request repeated.
	typedef struct {
		bit          is_cfg;
		logic        reg_sel;
		logic [31:0] reg_value;
		cmd_t        req;
		int unsigned reps;
		bit          fixed;
		res_t        want;
	} directed_row_t;

	directed_row_t directed_rows[$];

	// Enter a sequencer phase: reload the delay and set the line levels of that step.
	function automatic void enter_phase(input phase_t p);
		seq_phase = p;
		delay_left = delay_ticks_cfg;
		case (p)
			PH_ST0: sda_line = 1'b1;
			PH_ST1: scl_line = 1'b1;
			PH_ST2: sda_line = 1'b0;
			PH_ST5: scl_line = 1'b0;
			PH_TXH: begin
				sda_line = shifter[7];
				scl_line = 1'b1;
			end
			PH_TXL: begin
				shifter = shifter << 1;
				scl_line = 1'b0;
			end
			PH_POLL: begin
				sda_line = 1'b1;
				scl_line = 1'b1;
				poll_left = ack_timeout_cfg;
			end
			PH_RXH: scl_line = 1'b1;
			PH_RXL: scl_line = 1'b0;
			PH_RXA: begin
				sda_line = ack_to_drive;
				scl_line = 1'b1;
			end
			PH_SP0: sda_line = 1'b0;
			PH_SP1: scl_line = 1'b1;
			default: ;
		endcase
	endfunction

	// Advance the sequencer by one tick; returns 1 when a command completes.
	function automatic bit tick_sequencer(input logic sda);
		bit fin;
		fin = 1'b0;
		if (seq_phase == PH_POLL) begin
			if (!sda || poll_left == 0) begin
				ack_level = sda;
				scl_line = 1'b0;
				seq_phase = PH_IDLE;
				fin = 1'b1;
			end else begin
				poll_left--;
			end
		end else if (seq_phase != PH_IDLE) begin
			if (delay_left > 1) begin
				delay_left--;
			end else begin
				delay_left = '0;
				case (seq_phase)
					PH_ST7: begin
						bit_pos = '0;
						enter_phase(PH_TXH);
					end
					PH_TXH: enter_phase(PH_TXL);
					PH_TXL: begin
						bit_pos++;
						enter_phase(bit_pos < 8 ? PH_TXH : PH_POLL);
					end
					PH_RXH: begin
						shifter = {shifter[6:0], sda};
						enter_phase(PH_RXL);
					end
					PH_RXL: begin
						bit_pos++;
						enter_phase(bit_pos < 8 ? PH_RXH : PH_RXA);
					end
					PH_RXA: begin
						scl_line = 1'b0;
						last_read = shifter;
						seq_phase = PH_IDLE;
						fin = 1'b1;
					end
					PH_SP0, PH_SP1: enter_phase(phase_t'(seq_phase + 1));
					PH_SP2: begin
						sda_line = 1'b1;
						seq_phase = PH_IDLE;
						fin = 1'b1;
					end
					default: begin
						if (seq_phase >= PH_ST0 && seq_phase < PH_ST7)
							enter_phase(phase_t'(seq_phase + 1));
						else
							seq_phase = PH_IDLE;
					end
				endcase
			end
		end
		return fin;
	endfunction

	// Apply one request to the shadow sequencer and return the line state after it.
	function automatic res_t predict_lines(input cmd_t c);
		res_t r;
		bit   fin;
		logic rej;
		fin = 1'b0;
		rej = 1'b0;
		case (c.operation)
			OP_START, OP_SEND, OP_RECV, OP_STOP: begin
				if (seq_phase != PH_IDLE) begin
					rej = 1'b1;
				end else begin
					case (c.operation)
						OP_START: begin
							shifter = {c.target_address, c.read_not_write};
							enter_phase(PH_ST0);
						end
						OP_SEND: begin
							shifter = c.data_byte;
							bit_pos = '0;
							enter_phase(PH_TXH);
						end
						OP_RECV: begin
							sda_line = 1'b1;
							shifter = '0;
							bit_pos = '0;
							ack_to_drive = c.send_ack_level;
							enter_phase(PH_RXH);
						end
						default: enter_phase(PH_SP0);
					endcase
				end
			end
			default: fin = tick_sequencer(c.sda_level);
		endcase
		done_count += fin;
		reject_count += rej;
		r.scl_drive = scl_line;
		r.sda_drive = sda_line;
		r.busy_res = (seq_phase != PH_IDLE);
		r.done_res = fin;
		r.ack_seen = ack_level;
		r.read_byte = last_read;
		r.rejected = rej;
		return r;
	endfunction

	function automatic cmd_t make_request(input logic [2:0] op, input logic [7:0] data,
			input logic [6:0] addr, input logic rw, input logic ack, input logic sda);
		return '{op, data, addr, rw, ack, sda};
	endfunction

	function automatic res_t line_state(input logic scl, input logic sda, input logic busy,
			input logic fin, input logic ack, input logic [7:0] rbyte, input logic rej);
		return '{scl, sda, busy, fin, ack, rbyte, rej};
	endfunction

	function automatic cmd_t random_request();
		logic [31:0] w;
		w = $urandom;
		return w[$bits(cmd_t)-1:0];
	endfunction

	function automatic void plan_req(input cmd_t c, input int unsigned reps);
		directed_row_t r;
		r = '{1'b0, 1'b0, 32'd0, c, reps, 1'b0, res_t'('0)};
		directed_rows.push_back(r);
	endfunction

	function automatic void plan_fixed(input cmd_t c, input res_t want);
		directed_row_t r;
		r = '{1'b0, 1'b0, 32'd0, c, 1, 1'b1, want};
		directed_rows.push_back(r);
	endfunction

	function automatic void plan_cfg(input logic sel, input logic [31:0] value);
		directed_row_t r;
		r = '{1'b1, sel, value, cmd_t'('0), 0, 1'b0, res_t'('0)};
		directed_rows.push_back(r);
	endfunction

	// Present one request and hold it until the block takes it.
	task automatic send_request(input cmd_t c, input bit fixed, input res_t fixed_want);
		res_t want;
		cmd <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		want = predict_lines(c);
		expected_lines.push_back(fixed ? fixed_want : want);
		req_count++;
	endtask

	// Now and then leave the request channel empty for a short burst.
	task automatic maybe_pause();
		int unsigned n;
		if (!calm && $urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 16);
			cmd_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Feed ticks until the current command has finished.
	task automatic run_to_idle();
		cmd_t t;
		while (seq_phase != PH_IDLE) begin
			t = random_request();
			t.operation = OP_TICK;
			maybe_pause();
			send_request(t, 1'b0, res_t'('0));
		end
	endtask

	// Stop sending and wait for every outstanding result.
	task automatic drain();
		cmd_valid <= 1'b0;
		while (expected_lines.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write with setup and access cycles, only once the block is quiet.
	task automatic write_reg(input logic sel, input logic [31:0] value);
		run_to_idle();
		drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (sel == REG_DELAY_TICKS)
			delay_ticks_cfg = value[9:0];
		else
			ack_timeout_cfg = value[7:0];
	endtask

	// Random commands, each followed by ticks up to its completion, with some noise.
	task automatic random_phase(input logic [9:0] dly, input logic [7:0] tmo,
			input bit no_idle, input int unsigned items);
		cmd_t        c;
		bit          hold_high;
		int unsigned stop_at;
		int unsigned pick;
		write_reg(REG_DELAY_TICKS, {22'd0, dly});
		write_reg(REG_ACK_TIMEOUT, {24'd0, tmo});
		calm = no_idle;
		stop_at = req_count + items;
		while (req_count < stop_at) begin
			c = random_request();
			c.operation = 3'($urandom_range(OP_START, OP_STOP));
			// Holding SDA high gives timeouts on sends and all-ones bytes on receives.
			hold_high = ($urandom_range(0, 3) == 0);
			maybe_pause();
			send_request(c, 1'b0, res_t'('0));
			while (seq_phase != PH_IDLE) begin
				c = random_request();
				pick = $urandom_range(0, 39);
				if (pick == 0)
					c.operation = 3'($urandom_range(OP_START, OP_STOP));
				else if (pick == 1)
					c.operation = 3'($urandom_range(OP_RSVD5, OP_RSVD7));
				else
					c.operation = OP_TICK;
				if (hold_high)
					c.sda_level = 1'b1;
				maybe_pause();
				send_request(c, 1'b0, res_t'('0));
			end
			// An occasional tick or reserved code while nothing is in progress.
			if ($urandom_range(0, 7) == 0) begin
				c = random_request();
				c.operation = ($urandom_range(0, 1) == 0) ? OP_TICK :
					3'($urandom_range(OP_RSVD5, OP_RSVD7));
				maybe_pause();
				send_request(c, 1'b0, res_t'('0));
			end
		end
	endtask

	// Result checking, result-side stall bursts and the watchdog.
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				res_count++;
				if (expected_lines.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= SHOWN_MISMATCHES)
						$display("%0t: result %h arrived with nothing expected", $time, res);
				end else begin
					want = expected_lines.pop_front();
					if (res.scl_drive !== want.scl_drive || res.sda_drive !== want.sda_drive ||
							res.busy_res !== want.busy_res || res.done_res !== want.done_res ||
							res.ack_seen !== want.ack_seen || res.read_byte !== want.read_byte ||
							res.rejected !== want.rejected) begin
						mismatch_count++;
						if (mismatch_count <= SHOWN_MISMATCHES)
							$display({"%0t: expected scl=%b sda=%b busy=%b done=%b ack=%b ",
								"byte=%h rej=%b, got scl=%b sda=%b busy=%b done=%b ack=%b ",
								"byte=%h rej=%b"}, $time,
								want.scl_drive, want.sda_drive, want.busy_res, want.done_res,
								want.ack_seen, want.read_byte, want.rejected,
								res.scl_drive, res.sda_drive, res.busy_res, res.done_res,
								res.ack_seen, res.read_byte, res.rejected);
					end
				end
			end

			// The receiver stalls in random bursts.
			if (stall_left != 0) begin
				stall_left--;
				res_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 16) - 1;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end

			// Give up when neither channel moves for too long.
			if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("%0t: no request or result moved for %0d cycles", $time, IDLE_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		directed_row_t row;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Idle behavior after reset, including reserved codes.
		plan_fixed(make_request(OP_TICK, 8'h00, 7'h00, 1'b0, 1'b0, 1'b0),
			line_state(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0));
		plan_fixed(make_request(OP_RSVD5, 8'hFF, 7'h7F, 1'b1, 1'b1, 1'b1),
			line_state(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0));
		plan_fixed(make_request(OP_RSVD6, 8'h00, 7'h7F, 1'b0, 1'b1, 1'b0),
			line_state(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0));
		plan_fixed(make_request(OP_RSVD7, 8'hFF, 7'h00, 1'b1, 1'b0, 1'b1),
			line_state(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0));
		// A stop pulls SDA low; every command during it is turned away.
		plan_fixed(make_request(OP_STOP, 8'h3C, 7'h55, 1'b0, 1'b1, 1'b1),
			line_state(1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0));
		plan_fixed(make_request(OP_START, 8'h00, 7'h7F, 1'b1, 1'b0, 1'b0),
			line_state(1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b1));
		plan_fixed(make_request(OP_SEND, 8'hFF, 7'h00, 1'b0, 1'b0, 1'b0),
			line_state(1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b1));
		plan_fixed(make_request(OP_RECV, 8'h00, 7'h00, 1'b0, 1'b0, 1'b1),
			line_state(1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b1));
		plan_fixed(make_request(OP_STOP, 8'h00, 7'h00, 1'b0, 1'b0, 1'b0),
			line_state(1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b1));
		// Three delay units at the reset delay complete the stop.
		plan_req(make_request(OP_TICK, 8'h00, 7'h00, 1'b0, 1'b0, 1'b1), 90);

		// Shortest delay and no acknowledge wait.
		plan_cfg(REG_DELAY_TICKS, 32'd1);
		plan_cfg(REG_ACK_TIMEOUT, 32'd0);
		plan_req(make_request(OP_START, 8'h00, 7'h7F, 1'b1, 1'b0, 1'b0), 1);
		plan_req(make_request(OP_TICK, 8'h00, 7'h00, 1'b0, 1'b0, 1'b1), 25);
		plan_req(make_request(OP_SEND, 8'h00, 7'h00, 1'b0, 1'b0, 1'b0), 1);
		plan_req(make_request(OP_TICK, 8'h00, 7'h00, 1'b0, 1'b0, 1'b0), 17);
		plan_req(make_request(OP_RECV, 8'h00, 7'h00, 1'b0, 1'b0, 1'b0), 1);
		plan_req(make_request(OP_TICK, 8'h00, 7'h00, 1'b0, 1'b0, 1'b1), 17);
		plan_req(make_request(OP_RECV, 8'hFF, 7'h7F, 1'b1, 1'b1, 1'b1), 1);
		plan_req(make_request(OP_TICK, 8'h00, 7'h00, 1'b0, 1'b0, 1'b0), 17);
		plan_req(make_request(OP_START, 8'hFF, 7'h00, 1'b0, 1'b1, 1'b1), 1);
		plan_req(make_request(OP_TICK, 8'h00, 7'h00, 1'b0, 1'b0, 1'b0), 25);
		// A zero delay behaves as one tick per step.
		plan_cfg(REG_DELAY_TICKS, 32'd0);
		plan_req(make_request(OP_STOP, 8'h00, 7'h00, 1'b0, 1'b0, 1'b0), 1);
		plan_req(make_request(OP_TICK, 8'h00, 7'h00, 1'b0, 1'b0, 1'b0), 3);
		plan_req(make_request(OP_SEND, 8'hA5, 7'h00, 1'b0, 1'b0, 1'b0), 1);
		plan_req(make_request(OP_TICK, 8'h00, 7'h00, 1'b0, 1'b0, 1'b0), 17);
		// Longest acknowledge wait, left to run out.
		plan_cfg(REG_ACK_TIMEOUT, 32'd255);
		plan_req(make_request(OP_SEND, 8'h5A, 7'h00, 1'b0, 1'b0, 1'b0), 1);
		plan_req(make_request(OP_TICK, 8'h00, 7'h00, 1'b0, 1'b0, 1'b1), 272);
		// A long delay, on the shortest command.
		plan_cfg(REG_DELAY_TICKS, 32'd100);
		plan_req(make_request(OP_STOP, 8'h00, 7'h00, 1'b0, 1'b0, 1'b0), 1);
		plan_req(make_request(OP_TICK, 8'h00, 7'h00, 1'b0, 1'b0, 1'b0), 300);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.is_cfg) begin
				write_reg(row.reg_sel, row.reg_value);
			end else begin
				repeat (row.reps) begin
					maybe_pause();
					send_request(row.req, row.fixed, row.want);
				end
			end
		end

		// Random traffic under several register settings; the last part runs without gaps.
		random_phase(10'd1, 8'd0, 1'b0, 120);
		random_phase(10'd2, 8'd3, 1'b0, 120);
		random_phase(10'd0, 8'd255, 1'b1, 120);
		random_phase(10'd3, 8'd1, 1'b0, 120);
		random_phase(10'd1, 8'd255, 1'b0, 120);
		random_phase(10'($urandom_range(1, 4)), 8'($urandom_range(0, 255)), 1'b0, 120);
		random_phase(10'd1, 8'd2, 1'b1, 130);
		drain();

		$display("Sent %0d requests: %0d commands completed, %0d turned away while busy.",
			req_count, done_count, reject_count);
		$display("Checked %0d results, %0d mismatches.", res_count, mismatch_count);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
